### rtl/tcs_pkg.sv
// Shared constants and types for the threshold candidate scoring block.
package tcs_pkg;

    localparam int MaxItemsDefault = 64;
    localparam int ValueWidth      = 32;
    localparam int CategoryWidth   = 8;
    localparam int CountWidth      = 7;

    typedef logic signed [ValueWidth-1:0] value_t;
    typedef logic [CategoryWidth-1:0]     category_t;
    typedef logic [CountWidth-1:0]        count_t;

    // Scoring sequencer states, one-hot
    typedef enum logic [6:0] {
        ST_LOAD   = 7'b0000001,
        ST_EMPTY  = 7'b0000010,
        ST_FIND   = 7'b0000100,
        ST_FWAIT  = 7'b0001000,
        ST_SCORE  = 7'b0010000,
        ST_SWAIT  = 7'b0100000,
        ST_EMIT   = 7'b1000000
    } state_t;

endpackage

### rtl/threshold_candidate_scoring.sv
// Top level: sample store and threshold scoring sequencer.
// A non-final request of a tracked category is stored while space remains. After a final request each distinct
// value takes a find pass and a score pass (one memory read per cycle); each result is
// registered at the end of the next find pass, and the last one is sent when a find pass
// finds no larger value.
// Empty set: one result, registered from the EMPTY state. busy is high from the final request until the
// last result; the receiver cannot stall. Async active-low reset clears counts and state.
module threshold_candidate_scoring #(
    parameter int MAX_ITEMS = tcs_pkg::MaxItemsDefault
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [tcs_pkg::ValueWidth-1:0]    sample_value,
    input  logic [tcs_pkg::CategoryWidth-1:0]  sample_category,
    input  logic                               final_sample,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tcs_pkg::CategoryWidth-1:0]  cfg_data,
    output logic                               result_valid,
    output logic signed [tcs_pkg::ValueWidth-1:0]    threshold,
    output logic [tcs_pkg::CountWidth-1:0]     correct_count,
    output logic [tcs_pkg::CountWidth-1:0]     group_size,
    output logic                               from_upper,
    output logic                               last_result,
    output logic                               empty_set,
    output logic                               dropped_samples
);
    import tcs_pkg::*;

    localparam int AddrWidth = $clog2(MAX_ITEMS);
    localparam count_t MaxCount = count_t'(MAX_ITEMS);

    // sample memory: value and group bit in one word
    logic [ValueWidth:0] mem [MAX_ITEMS];
    logic [ValueWidth:0] rd_data_reg;

    category_t lower_cat_reg;
    count_t    lower_count_reg, lower_count_next;
    count_t    upper_count_reg, upper_count_next;
    logic      overflow_reg, overflow_next;
    state_t    state_reg, state_next;
    count_t    ptr_reg, ptr_next;          // read pointer for the passes
    logic      rd_valid_reg, rd_valid_next;
    value_t    prev_reg, prev_next;        // last emitted threshold
    logic      have_prev_reg, have_prev_next;
    value_t    cand_reg, cand_next;        // smallest value above prev
    logic      have_cand_reg, have_cand_next;
    count_t    correct_reg, correct_next;
    logic      in_lower_reg, in_lower_next;

    logic      res_valid_reg, res_valid_next;
    value_t    res_thr_reg, res_thr_next;
    count_t    res_cnt_reg, res_cnt_next;
    count_t    res_size_reg, res_size_next;
    logic      res_upper_reg, res_upper_next;
    logic      res_last_reg, res_last_next;
    logic      res_empty_reg, res_empty_next;
    logic      res_drop_reg, res_drop_next;

    logic      accept;
    logic      is_lower, is_upper;
    count_t    total;
    logic      wr_en;
    value_t    rd_val;
    logic      rd_grp;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_LOAD);
    assign cfg_ready = !busy;
    assign is_lower  = (sample_category == lower_cat_reg);
    assign is_upper  = ({1'b0, sample_category} == {1'b0, lower_cat_reg} + 9'd1);
    assign total     = lower_count_reg + upper_count_reg;
    assign wr_en     = accept && (is_lower || is_upper) && (total < MaxCount);
    assign rd_val    = value_t'(rd_data_reg[ValueWidth-1:0]);
    assign rd_grp    = rd_data_reg[ValueWidth];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[total[AddrWidth-1:0]] <= {is_upper, sample_value};
        end
        rd_data_reg <= mem[ptr_reg[AddrWidth-1:0]];
    end

    always_comb
    begin
        state_next       = state_reg;
        lower_count_next = lower_count_reg;
        upper_count_next = upper_count_reg;
        overflow_next    = overflow_reg;
        ptr_next         = ptr_reg;
        rd_valid_next    = 1'b0;
        prev_next        = prev_reg;
        have_prev_next   = have_prev_reg;
        cand_next        = cand_reg;
        have_cand_next   = have_cand_reg;
        correct_next     = correct_reg;
        in_lower_next    = in_lower_reg;
        res_valid_next   = 1'b0;
        res_thr_next     = res_thr_reg;
        res_cnt_next     = res_cnt_reg;
        res_size_next    = res_size_reg;
        res_upper_next   = res_upper_reg;
        res_last_next    = res_last_reg;
        res_empty_next   = res_empty_reg;
        res_drop_next    = res_drop_reg;

        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (is_lower || is_upper)
                    begin
                        if (total < MaxCount)
                        begin
                            if (is_upper)
                                upper_count_next = upper_count_reg + count_t'(1);
                            else
                                lower_count_next = lower_count_reg + count_t'(1);
                        end
                        else
                        begin
                            overflow_next = 1'b1;
                        end
                    end
                    if (final_sample)
                    begin
                        have_prev_next = 1'b0;
                        if (lower_count_next == '0 && upper_count_next == '0)
                            state_next = ST_EMPTY;
                        else
                        begin
                            state_next     = ST_FIND;
                            ptr_next       = '0;
                            have_cand_next = 1'b0;
                        end
                    end
                end
            end
            ST_EMPTY:
            begin
                res_valid_next   = 1'b1;
                res_thr_next     = '0;
                res_cnt_next     = '0;
                res_size_next    = '0;
                res_upper_next   = 1'b0;
                res_last_next    = 1'b1;
                res_empty_next   = 1'b1;
                res_drop_next    = overflow_reg;
                overflow_next    = 1'b0;
                state_next       = ST_LOAD;
            end
            // pass 1: find smallest stored value above the previous threshold
            ST_FIND:
            begin
                if (rd_valid_reg && (!have_prev_reg || rd_val > prev_reg)
                    && (!have_cand_reg || rd_val < cand_reg))
                begin
                    cand_next      = rd_val;
                    have_cand_next = 1'b1;
                end
                if (ptr_reg == total)
                    state_next = ST_FWAIT;
                else
                begin
                    rd_valid_next = 1'b1;
                    ptr_next      = ptr_reg + count_t'(1);
                end
            end
            ST_FWAIT:
            begin
                state_next    = ST_SCORE;
                ptr_next      = '0;
                correct_next  = '0;
                in_lower_next = 1'b0;
            end
            // pass 2: count correct samples for the candidate
            ST_SCORE:
            begin
                if (rd_valid_reg)
                begin
                    if (rd_grp ? (rd_val >= cand_reg) : (rd_val < cand_reg))
                        correct_next = correct_reg + count_t'(1);
                    if (!rd_grp && rd_val == cand_reg)
                        in_lower_next = 1'b1;
                end
                if (ptr_reg == total)
                    state_next = ST_SWAIT;
                else
                begin
                    rd_valid_next = 1'b1;
                    ptr_next      = ptr_reg + count_t'(1);
                end
            end
            ST_SWAIT:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                res_valid_next = 1'b1;
                res_thr_next   = cand_reg;
                res_cnt_next   = correct_reg;
                res_size_next  = in_lower_reg ? lower_count_reg : upper_count_reg;
                res_upper_next = !in_lower_reg;
                res_empty_next = 1'b0;
                res_drop_next  = overflow_reg;
                // last if nothing bigger exists: check with another find pass
                prev_next      = cand_reg;
                have_prev_next = 1'b1;
                have_cand_next = 1'b0;
                ptr_next       = '0;
                res_last_next  = 1'b0;
                state_next     = ST_FIND;
                res_valid_next = 1'b0;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        // a held result goes out when the next find pass ends
        if (state_reg == ST_FWAIT && have_prev_reg)
        begin
            res_valid_next = 1'b1;
            res_last_next  = !have_cand_reg;
            if (!have_cand_reg)
            begin
                state_next       = ST_LOAD;
                lower_count_next = '0;
                upper_count_next = '0;
                overflow_next    = 1'b0;
            end
        end
    end

    // pending result held between EMIT and the following FWAIT
    value_t pend_thr_reg;
    count_t pend_cnt_reg, pend_size_reg;
    logic   pend_upper_reg, pend_drop_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EMIT)
        begin
            pend_thr_reg   <= res_thr_next;
            pend_cnt_reg   <= res_cnt_next;
            pend_size_reg  <= res_size_next;
            pend_upper_reg <= res_upper_next;
            pend_drop_reg  <= res_drop_next;
        end
        prev_reg     <= prev_next;
        cand_reg     <= cand_next;
        correct_reg  <= correct_next;
        in_lower_reg <= in_lower_next;
        res_thr_reg  <= (state_reg == ST_FWAIT) ? pend_thr_reg : res_thr_next;
        res_cnt_reg  <= (state_reg == ST_FWAIT) ? pend_cnt_reg : res_cnt_next;
        res_size_reg <= (state_reg == ST_FWAIT) ? pend_size_reg : res_size_next;
        res_upper_reg <= (state_reg == ST_FWAIT) ? pend_upper_reg : res_upper_next;
        res_drop_reg <= (state_reg == ST_FWAIT) ? pend_drop_reg : res_drop_next;
        res_empty_reg <= res_empty_next;
        res_last_reg  <= res_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_LOAD;
            lower_cat_reg   <= '0;
            lower_count_reg <= '0;
            upper_count_reg <= '0;
            overflow_reg    <= 1'b0;
            ptr_reg         <= '0;
            rd_valid_reg    <= 1'b0;
            have_prev_reg   <= 1'b0;
            have_cand_reg   <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            lower_count_reg <= lower_count_next;
            upper_count_reg <= upper_count_next;
            overflow_reg    <= overflow_next;
            ptr_reg         <= ptr_next;
            rd_valid_reg    <= rd_valid_next;
            have_prev_reg   <= have_prev_next;
            have_cand_reg   <= have_cand_next;
            res_valid_reg   <= res_valid_next;
            if (cfg_valid && cfg_ready)
                lower_cat_reg <= cfg_data;
        end
    end

    assign result_valid    = res_valid_reg;
    assign threshold       = res_thr_reg;
    assign correct_count   = res_cnt_reg;
    assign group_size      = res_size_reg;
    assign from_upper      = res_upper_reg;
    assign last_result     = res_last_reg;
    assign empty_set       = res_empty_reg;
    assign dropped_samples = res_drop_reg;

    // counts never exceed capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        (lower_count_reg + upper_count_reg) <= MaxCount)
        else $error("sample count above capacity");
    // a final request always leaves the load state
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && final_sample |=> busy)
        else $error("final request did not start scoring");
    // stores are cleared once the last result has gone
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_result |-> lower_count_reg == '0 && upper_count_reg == '0)
        else $error("counts not cleared at end of run");
    // the empty marker only on a final result
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && empty_set |-> last_result)
        else $error("empty result not marked last");

endmodule

### tb/sv/tb.sv
// Testbench for threshold_candidate_scoring: directed and random sample sets, scored on the fly.
`timescale 1ns / 100ps

module tb;
    import tcs_pkg::*;

    localparam int MaxItems = 64;
    localparam int WatchLimit = 40000;

    typedef struct packed {
        logic signed [31:0] thr;
        logic [6:0]         correct;
        logic [6:0]         gsize;
        logic               upper;
        logic               last;
        logic               empty;
        logic               dropped;
    } score_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [31:0] sample_value = '0;
    logic [7:0] sample_category = '0;
    logic final_sample = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [7:0] cfg_data = '0;
    logic result_valid;
    logic signed [31:0] threshold;
    logic [6:0] correct_count;
    logic [6:0] group_size;
    logic from_upper;
    logic last_result;
    logic empty_set;
    logic dropped_samples;

    threshold_candidate_scoring uut (.*);

    always #6 clk = ~clk;

    // predictor state
    logic signed [31:0] pv_val [MaxItems];
    logic               pv_up  [MaxItems];
    int                 n_lower, n_upper;
    logic               ovf;
    logic [7:0]         low_cat;
    score_t             pending_scores[$];
    int                 errors = 0;
    int                 idle_cycles = 0;
    int                 gap_pct = 0;

    task automatic score_set();
        int n;
        logic signed [31:0] srt [MaxItems];
        logic signed [31:0] v, t;
        int j, c;
        bit inl;
        score_t s;
        n = n_lower + n_upper;
        if (n == 0) begin
            s = '0;
            s.last = 1'b1;
            s.empty = 1'b1;
            s.dropped = ovf;
            pending_scores.insert(pending_scores.size(), s);
        end else begin
            for (int i = 0; i < n; i++) begin
                v = pv_val[i];
                j = i;
                while (j > 0 && srt[j-1] > v) begin
                    srt[j] = srt[j-1];
                    j--;
                end
                srt[j] = v;
            end
            for (int i = 0; i < n; i++) begin
                t = srt[i];
                if (i > 0 && srt[i-1] == t) continue;
                c = 0;
                inl = 0;
                for (int k = 0; k < n; k++) begin
                    if (pv_up[k]) begin
                        if (pv_val[k] >= t) c++;
                    end else begin
                        if (pv_val[k] < t) c++;
                        if (pv_val[k] == t) inl = 1;
                    end
                end
                s = '0;
                s.thr = t;
                s.correct = 7'(c);
                s.gsize = 7'(inl ? n_lower : n_upper);
                s.upper = !inl;
                s.dropped = ovf;
                pending_scores.insert(pending_scores.size(), s);
            end
            s = pending_scores[pending_scores.size() - 1];
            s.last = 1'b1;
            pending_scores[pending_scores.size() - 1] = s;
        end
        n_lower = 0;
        n_upper = 0;
        ovf = 0;
    endtask

    // start stays high after a request; the next request or drain() takes it down
    task automatic load_sample(input logic signed [31:0] v, input logic [7:0] cat, input bit fin);
        int tot;
        bit lo, up;
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        sample_value <= v;
        sample_category <= cat;
        final_sample <= fin;
        @(posedge clk);
        while (busy) @(posedge clk);
        tot = n_lower + n_upper;
        lo = (cat == low_cat);
        up = ({1'b0, cat} == {1'b0, low_cat} + 9'd1);
        if (lo || up) begin
            if (tot < MaxItems) begin
                pv_val[tot] = v;
                pv_up[tot] = up;
                if (up) n_upper++;
                else n_lower++;
            end else begin
                ovf = 1;
            end
        end
        if (fin) score_set();
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_scores.size() != 0 || busy) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_lower_category(input logic [7:0] c);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= c;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        low_cat = c;
    endtask

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(4))
            0: return 32'sh8000_0000 + $urandom_range(3);
            1: return 32'sh7fff_fffc + $urandom_range(3);
            2: return $signed(32'($urandom_range(8)) - 32'd4) <<< 16;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [7:0] rand_cat();
        int r;
        r = $urandom_range(9);
        if (r < 4) return low_cat;
        if (r < 8) return low_cat + 8'd1;
        return 8'($urandom());
    endfunction

    task automatic random_set(input int len);
        for (int i = 0; i < len; i++)
            load_sample(rand_value(), rand_cat(), i == len - 1);
    endtask

    task automatic test_directed();
        set_lower_category(8'd0);
        load_sample(32'sd5, 8'd7, 1);                  // empty set
        load_sample(32'sh8000_0000, 8'd0, 0);
        load_sample(32'sh7fff_ffff, 8'd1, 0);
        load_sample(32'sd0, 8'd0, 0);
        load_sample(32'sd0, 8'd1, 0);                  // value in both groups
        load_sample(-32'sd65536, 8'd1, 0);
        load_sample(32'sd3, 8'd2, 1);                  // ignored category on the final request
        set_lower_category(8'd255);                    // upper group unreachable
        load_sample(32'sd1, 8'd255, 0);
        load_sample(32'sd2, 8'd0, 0);
        load_sample(32'sd1, 8'd255, 1);
        set_lower_category(8'd128);
        load_sample(32'sd9, 8'd129, 1);                // upper only
    endtask

    task automatic test_overflow();
        set_lower_category(8'd10);
        for (int i = 0; i < 70; i++)
            load_sample(rand_value(), $urandom_range(1) ? 8'd10 : 8'd11, i == 69);
        for (int i = 0; i < 66; i++)
            load_sample(rand_value(), 8'd11, 0);
        load_sample(32'sd0, 8'd3, 1);
    endtask

    task automatic test_random(input int pct);
        gap_pct = pct;
        for (int s = 0; s < 17; s++) begin
            if (s % 7 == 6) set_lower_category(8'($urandom()));
            random_set($urandom_range(1, 12));
        end
    endtask

    // result checker
    always @(posedge clk) begin
        score_t e;
        if (rst_n && result_valid) begin
            if (pending_scores.size() == 0) begin
                $error("result with nothing expected: threshold %0d", threshold);
                errors++;
            end else begin
                e = pending_scores.pop_front();
                if (threshold !== e.thr) begin
                    $error("threshold exp %0d got %0d", e.thr, threshold); errors++;
                end
                if (correct_count !== e.correct) begin
                    $error("correct_count exp %0d got %0d", e.correct, correct_count); errors++;
                end
                if (group_size !== e.gsize) begin
                    $error("group_size exp %0d got %0d", e.gsize, group_size); errors++;
                end
                if (from_upper !== e.upper) begin
                    $error("from_upper exp %0d got %0d", e.upper, from_upper); errors++;
                end
                if (last_result !== e.last) begin
                    $error("last_result exp %0d got %0d", e.last, last_result); errors++;
                end
                if (empty_set !== e.empty) begin
                    $error("empty_set exp %0d got %0d", e.empty, empty_set); errors++;
                end
                if (dropped_samples !== e.dropped) begin
                    $error("dropped_samples exp %0d got %0d", e.dropped, dropped_samples);
                    errors++;
                end
            end
        end
    end

    // watchdog: cycles with no request, result or register write
    always @(posedge clk) begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WatchLimit) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        n_lower = 0;
        n_upper = 0;
        ovf = 0;
        low_cat = 8'd0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_overflow();
        test_random(28);
        test_random(48);
        test_random(0);
        drain();
        if (errors == 0 && pending_scores.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
